/* rtl/assert_macros.svh */
// Assertion macros used by the back part of the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define CHECK_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("invariant check failed");

// Checks that a condition is followed by a consequence in the next cycle.
`define CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sequence check failed");

`endif

/* rtl/ccls_pkg.sv */
// Types and constants shared by the lattice step modules.
package ccls_pkg;

    localparam int LAT_AW_MAX = 20;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int SPECIES_N  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_REPRODUCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPETE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_EARLY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_LATE  = 2'd3;

    localparam logic [CFG_W-1:0] REPRODUCE_RST  = 17'd32768;
    localparam logic [CFG_W-1:0] COMPETE_RST    = 17'd16384;
    localparam logic [CFG_W-1:0] WEAK_EARLY_RST = 17'd65536;
    localparam logic [CFG_W-1:0] WEAK_LATE_RST  = 17'd65536;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    localparam logic [2:0] DIR_YP   = 3'd0;
    localparam logic [2:0] DIR_YM   = 3'd1;
    localparam logic [2:0] DIR_XP   = 3'd2;
    localparam logic [2:0] DIR_XM   = 3'd3;
    localparam logic [2:0] DIR_XPYP = 3'd4;
    localparam logic [2:0] DIR_XMYM = 3'd5;
    localparam logic [2:0] DIR_XMYP = 3'd6;
    localparam logic [2:0] DIR_XPYM = 3'd7;

    localparam logic [2:0] OUT_LOADED     = 3'd0;
    localparam logic [2:0] OUT_EMPTY      = 3'd1;
    localparam logic [2:0] OUT_REPRODUCED = 3'd2;
    localparam logic [2:0] OUT_PREDATED   = 3'd3;
    localparam logic [2:0] OUT_MOVED      = 3'd4;
    localparam logic [2:0] OUT_NO_EFFECT  = 3'd5;

    localparam logic [2:0] SPECIES_EMPTY = 3'd0;
    localparam logic [2:0] SPECIES_LAST  = 3'd5;
    localparam logic [2:0] SPECIES_FIRST = 3'd1;
    localparam logic [2:0] SPECIES_EARLY_MAX = 3'd2;

    typedef enum logic [1:0] {
        ACT_REPRODUCE,
        ACT_PREDATE,
        ACT_MOVE
    } t_act;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [2:0]  load_species;
        logic [2:0]  direction;
        logic [15:0] action_draw;
        logic [15:0] weakness_draw;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [2:0]  victim_species;
        logic [16:0] pop_one;
        logic [16:0] pop_two;
        logic [16:0] pop_three;
        logic [16:0] pop_four;
        logic [16:0] pop_five;
        logic [31:0] success_count;
        logic        sweep_done;
        logic        extinct;
    } t_out_item;

    typedef struct packed {
        logic                  req_type;
        logic [LAT_AW_MAX-1:0] addr_a;
        logic [LAT_AW_MAX-1:0] addr_p;
        logic [2:0]            load_species;
        t_act                  act;
        logic                  pass_early;
        logic                  pass_late;
    } t_cmd;

endpackage

/* rtl/cyclic_competition_lattice_step_top.sv */
// Top level of the cyclic competition lattice step block.
// After reset the block clears the lattice, one cell a cycle, and takes no item in that
// time; configuration writes are taken throughout. Each item then takes a read state
// and an execute state that writes at most one cell, as the lattice memory has one write
// port; a mobility event writes both cells and takes a further write state. Input items
// queue two deep in front of the memory, and a result waits in an output register, so the
// input side takes up to three more items while a result is held. An accepted item passes
// through the queue, the read state and the execute state before its result is registered.
module cyclic_competition_lattice_step_top
    import ccls_pkg::*;
#(
    parameter int GRID_W = 256,
    parameter int GRID_H = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_item
);

    logic w_hold;
    logic w_fq_valid, w_fq_ready;
    t_cmd w_fq_cmd;
    logic w_qb_valid, w_qb_ready;
    t_cmd w_qb_cmd;

    ccls_front #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_hold      (w_hold),
        .o_cmd_valid (w_fq_valid),
        .i_cmd_ready (w_fq_ready),
        .o_cmd       (w_fq_cmd)
    );

    ccls_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_cmd   (w_fq_cmd),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_cmd    (w_qb_cmd)
    );

    ccls_back #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qb_valid),
        .o_cmd_ready (w_qb_ready),
        .i_cmd       (w_qb_cmd),
        .o_clearing  (w_hold),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

/* rtl/ccls_front.sv */
// Front part: configuration registers, address generation and action classification.
module ccls_front
    import ccls_pkg::*;
#(
    parameter int GRID_W = 256,
    parameter int GRID_H = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    input  logic                 i_hold,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output t_cmd                 o_cmd
);

    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);

    logic [CFG_W-1:0] r_reproduce_prob;
    logic [CFG_W-1:0] r_compete_prob;
    logic [CFG_W-1:0] r_weak_early;
    logic [CFG_W-1:0] r_weak_late;

    logic [XW-1:0] w_xmod_tab [256];
    logic [YW-1:0] w_ymod_tab [256];
    logic [XW-1:0] w_cx, w_xp, w_xm, w_nx;
    logic [YW-1:0] w_cy, w_yp, w_ym, w_ny;
    logic [AW-1:0] w_addr_a, w_addr_p;
    logic [CFG_W:0] w_band_sum;
    t_act           w_act;

    for (genvar g = 0; g < 256; g++) begin : g_mod_tab
        assign w_xmod_tab[g] = XW'(g % GRID_W);
        assign w_ymod_tab[g] = YW'(g % GRID_H);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reproduce_prob <= REPRODUCE_RST;
            r_compete_prob   <= COMPETE_RST;
            r_weak_early     <= WEAK_EARLY_RST;
            r_weak_late      <= WEAK_LATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REPRODUCE:  r_reproduce_prob <= i_cfg_data;
                CFG_COMPETE:    r_compete_prob   <= i_cfg_data;
                CFG_WEAK_EARLY: r_weak_early     <= i_cfg_data;
                CFG_WEAK_LATE:  r_weak_late      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cx = w_xmod_tab[i_item.cell_x];
    assign w_cy = w_ymod_tab[i_item.cell_y];
    assign w_xp = (w_cx == XW'(GRID_W - 1)) ? '0 : w_cx + 1'b1;
    assign w_xm = (w_cx == '0) ? XW'(GRID_W - 1) : w_cx - 1'b1;
    assign w_yp = (w_cy == YW'(GRID_H - 1)) ? '0 : w_cy + 1'b1;
    assign w_ym = (w_cy == '0) ? YW'(GRID_H - 1) : w_cy - 1'b1;

    always_comb begin
        w_nx = w_cx;
        w_ny = w_cy;
        unique case (i_item.direction)
            DIR_YP:   w_ny = w_yp;
            DIR_YM:   w_ny = w_ym;
            DIR_XP:   w_nx = w_xp;
            DIR_XM:   w_nx = w_xm;
            DIR_XPYP: begin w_nx = w_xp; w_ny = w_yp; end
            DIR_XMYM: begin w_nx = w_xm; w_ny = w_ym; end
            DIR_XMYP: begin w_nx = w_xm; w_ny = w_yp; end
            DIR_XPYM: begin w_nx = w_xp; w_ny = w_ym; end
            default: ;
        endcase
    end

    assign w_addr_a = AW'(w_cy) * AW'(GRID_W) + AW'(w_cx);
    assign w_addr_p = AW'(w_ny) * AW'(GRID_W) + AW'(w_nx);

    assign w_band_sum = {1'b0, r_reproduce_prob} + {1'b0, r_compete_prob};

    always_comb begin
        if ({1'b0, i_item.action_draw} < r_reproduce_prob) begin
            w_act = ACT_REPRODUCE;
        end else if ({2'b0, i_item.action_draw} < w_band_sum) begin
            w_act = ACT_PREDATE;
        end else begin
            w_act = ACT_MOVE;
        end
    end

    always_comb begin
        o_cmd.req_type     = i_item.req_type;
        o_cmd.addr_a       = LAT_AW_MAX'(w_addr_a);
        o_cmd.addr_p       = LAT_AW_MAX'(w_addr_p);
        o_cmd.load_species = (i_item.load_species > SPECIES_LAST) ? SPECIES_EMPTY
                                                                  : i_item.load_species;
        o_cmd.act          = w_act;
        o_cmd.pass_early   = {1'b0, i_item.weakness_draw} < r_weak_early;
        o_cmd.pass_late    = {1'b0, i_item.weakness_draw} < r_weak_late;
    end

    assign o_cmd_valid = i_valid && !i_hold;
    assign o_ready     = i_cmd_ready && !i_hold;

endmodule

/* rtl/ccls_queue.sv */
// Two-entry command queue between the front and back parts.
module ccls_queue
    import ccls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_slot[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* rtl/ccls_back.sv */
// Back part: lattice memory, population counts, success counter and result register.
`include "assert_macros.svh"

module ccls_back
    import ccls_pkg::*;
#(
    parameter int GRID_W = 256,
    parameter int GRID_H = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_clearing,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW    = $clog2(CELLS);
    localparam int CW_I  = $clog2(CELLS + 1);
    localparam int CNT_W = (CW_I > 17) ? CW_I : 17;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_RD,
        S_EX,
        S_WR2
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_addr;
    t_cmd            r_cmd;
    logic [2:0]      r_rd_a;
    logic [2:0]      r_rd_p;
    logic [2:0]      r_lat [CELLS];
    logic [CNT_W-1:0] r_cnt [SPECIES_N];
    logic [31:0]     r_succ;
    logic [AW-1:0]   r_mod;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [CNT_W-1:0] n_cnt [SPECIES_N];
    logic [31:0]     n_succ;
    logic [AW-1:0]   n_mod;
    t_out_item       n_out;

    logic            w_rd_en;
    logic            w_commit;
    logic            w_active_ok;
    logic [2:0]      w_prey;
    logic            w_pass;
    logic [2:0]      w_outcome;
    logic [2:0]      w_victim;
    logic [2:0]      w_inc_sp;
    logic [2:0]      w_dec_sp;
    logic            w_success;
    logic            w_sweep;
    logic            w_extinct;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [2:0]      w_wdata;
    logic            w_victim_ok;

    assign o_cmd_ready = (r_state == S_RD);
    assign o_clearing  = (r_state == S_CLEAR);
    assign w_rd_en     = (r_state == S_RD) && i_cmd_valid;
    assign w_commit    = (r_state == S_EX) && (!r_out_valid || i_ready);

    assign w_active_ok = (r_rd_a != SPECIES_EMPTY) && (r_rd_a <= SPECIES_LAST);
    assign w_prey      = (r_rd_a == SPECIES_LAST) ? SPECIES_FIRST : r_rd_a + 3'd1;
    assign w_pass      = (r_rd_a <= SPECIES_EARLY_MAX) ? r_cmd.pass_early : r_cmd.pass_late;

    always_comb begin
        w_outcome = OUT_NO_EFFECT;
        w_victim  = SPECIES_EMPTY;
        w_inc_sp  = SPECIES_EMPTY;
        w_dec_sp  = SPECIES_EMPTY;
        w_success = 1'b0;
        if (r_cmd.req_type == REQ_LOAD) begin
            w_outcome = OUT_LOADED;
            w_dec_sp  = r_rd_a;
            w_inc_sp  = r_cmd.load_species;
        end else if (!w_active_ok) begin
            w_outcome = OUT_EMPTY;
        end else begin
            unique case (r_cmd.act)
                ACT_REPRODUCE: begin
                    if (r_rd_p == SPECIES_EMPTY) begin
                        w_outcome = OUT_REPRODUCED;
                        w_inc_sp  = r_rd_a;
                        w_success = 1'b1;
                    end
                end
                ACT_PREDATE: begin
                    if (w_pass && (r_rd_p == w_prey)) begin
                        w_outcome = OUT_PREDATED;
                        w_victim  = w_prey;
                        w_dec_sp  = w_prey;
                        w_success = 1'b1;
                    end
                end
                ACT_MOVE: begin
                    w_outcome = OUT_MOVED;
                    w_success = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_extinct = 1'b0;
        for (int k = 0; k < SPECIES_N; k++) begin
            n_cnt[k] = r_cnt[k];
            if ((w_dec_sp == 3'(k + 1)) && (r_cnt[k] != '0)) begin
                n_cnt[k] = n_cnt[k] - 1'b1;
            end
            if (w_inc_sp == 3'(k + 1)) begin
                n_cnt[k] = n_cnt[k] + 1'b1;
            end
            if (n_cnt[k] == '0) begin
                w_extinct = 1'b1;
            end
        end
    end

    always_comb begin
        n_succ  = r_succ + {31'b0, w_success};
        n_mod   = r_mod;
        w_sweep = 1'b0;
        if (w_success) begin
            if ((n_succ == 32'd0) || (r_mod == AW'(CELLS - 1))) begin
                n_mod   = '0;
                w_sweep = 1'b1;
            end else begin
                n_mod = r_mod + 1'b1;
            end
        end
    end

    always_comb begin
        n_out.outcome        = w_outcome;
        n_out.victim_species = w_victim;
        n_out.pop_one        = n_cnt[0][16:0];
        n_out.pop_two        = n_cnt[1][16:0];
        n_out.pop_three      = n_cnt[2][16:0];
        n_out.pop_four       = n_cnt[3][16:0];
        n_out.pop_five       = n_cnt[4][16:0];
        n_out.success_count  = n_succ;
        n_out.sweep_done     = w_sweep;
        n_out.extinct        = w_extinct;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_cmd.addr_p);
        w_wdata = r_rd_a;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = SPECIES_EMPTY;
            end
            S_EX: begin
                if (w_commit) begin
                    if (r_cmd.req_type == REQ_LOAD) begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_cmd.addr_a);
                        w_wdata = r_cmd.load_species;
                    end else if (w_success) begin
                        w_we    = 1'b1;
                        w_wdata = (w_outcome == OUT_PREDATED) ? SPECIES_EMPTY : r_rd_a;
                    end
                end
            end
            S_WR2: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_cmd.addr_a);
                w_wdata = r_rd_p;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_lat[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_a <= r_lat[AW'(i_cmd.addr_a)];
            r_rd_p <= r_lat[AW'(i_cmd.addr_p)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_succ      <= '0;
            r_mod       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SPECIES_N; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(CELLS - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EX;
                    end
                end
                S_EX: begin
                    if (w_commit) begin
                        r_succ <= n_succ;
                        r_mod  <= n_mod;
                        for (int k = 0; k < SPECIES_N; k++) begin
                            r_cnt[k] <= n_cnt[k];
                        end
                        r_state <= (w_outcome == OUT_MOVED) ? S_WR2 : S_RD;
                    end
                end
                S_WR2: begin
                    r_state <= S_RD;
                end
                default: r_state <= S_RD;
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    assign w_victim_ok = (r_out.outcome == OUT_PREDATED) ==
                         (r_out.victim_species != SPECIES_EMPTY);

    `CHECK_NEXT(a_commit_shows, w_commit, r_out_valid)
    `CHECK_ALWAYS(a_victim_iff_pred, !r_out_valid || w_victim_ok)
    `CHECK_NEXT(a_succ_step, w_commit && w_success, r_succ == $past(r_succ) + 32'd1)
    `CHECK_NEXT(a_move_second_write, w_commit && (w_outcome == OUT_MOVED), r_state == S_WR2)

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the cyclic competition lattice step block.
module tb_top;
    import ccls_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW = 256;
    localparam int GH = 256;
    localparam int NCELLS = GW * GH;
    localparam int WATCHDOG = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_REPRODUCE;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in_item i_item = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out_item o_item;

    cyclic_competition_lattice_step_top #(.GRID_W(GW), .GRID_H(GH)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [2:0] grid [NCELLS];
    logic [31:0] pop [5];
    logic [31:0] wins;
    logic [16:0] p_repro, p_comp, p_weak_e, p_weak_l;

    t_out_item due_q [$];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int n_moves = 0, n_preds = 0, n_repros = 0;
    bit hold_off = 1'b0;
    bit random_stall = 1'b0;

    function automatic int cell_of(logic [7:0] x, logic [7:0] y);
        return (int'(y) % GH) * GW + (int'(x) % GW);
    endfunction

    function automatic void pop_dec(logic [2:0] s);
        if (s >= SPECIES_FIRST && s <= SPECIES_LAST && pop[s - 1] > 0) pop[s - 1]--;
    endfunction

    function automatic t_out_item lattice_step(t_in_item it);
        t_out_item r;
        int a, cx, cy, nx, ny, p;
        logic [2:0] s, sp, prey, tmp;
        logic [16:0] thr;
        bit ok;
        r = '0;
        ok = 1'b0;
        a = cell_of(it.cell_x, it.cell_y);
        r.outcome = OUT_LOADED;
        if (it.req_type == REQ_LOAD) begin
            sp = (it.load_species > SPECIES_LAST) ? SPECIES_EMPTY : it.load_species;
            pop_dec(grid[a]);
            grid[a] = sp;
            if (sp != SPECIES_EMPTY) pop[sp - 1]++;
        end else begin
            s = grid[a];
            if (s == SPECIES_EMPTY || s > SPECIES_LAST) begin
                r.outcome = OUT_EMPTY;
            end else begin
                cx = int'(it.cell_x) % GW;
                cy = int'(it.cell_y) % GH;
                nx = cx;
                ny = cy;
                case (it.direction)
                    DIR_YP: ny = cy + 1;
                    DIR_YM: ny = cy - 1;
                    DIR_XP: nx = cx + 1;
                    DIR_XM: nx = cx - 1;
                    DIR_XPYP: begin nx = cx + 1; ny = cy + 1; end
                    DIR_XMYM: begin nx = cx - 1; ny = cy - 1; end
                    DIR_XMYP: begin nx = cx - 1; ny = cy + 1; end
                    default: begin nx = cx + 1; ny = cy - 1; end
                endcase
                nx = (nx + GW) % GW;
                ny = (ny + GH) % GH;
                p = ny * GW + nx;
                r.outcome = OUT_NO_EFFECT;
                if ({1'b0, it.action_draw} < p_repro) begin
                    if (grid[p] == SPECIES_EMPTY) begin
                        grid[p] = s;
                        pop[s - 1]++;
                        r.outcome = OUT_REPRODUCED;
                        ok = 1'b1;
                    end
                end else if ({2'b0, it.action_draw} < {1'b0, p_repro} + {1'b0, p_comp}) begin
                    thr = (s <= SPECIES_EARLY_MAX) ? p_weak_e : p_weak_l;
                    prey = (s == SPECIES_LAST) ? SPECIES_FIRST : s + 3'd1;
                    if ({1'b0, it.weakness_draw} < thr && grid[p] == prey) begin
                        grid[p] = SPECIES_EMPTY;
                        pop_dec(prey);
                        r.victim_species = prey;
                        r.outcome = OUT_PREDATED;
                        ok = 1'b1;
                    end
                end else begin
                    tmp = grid[p];
                    grid[p] = grid[a];
                    grid[a] = tmp;
                    r.outcome = OUT_MOVED;
                    ok = 1'b1;
                end
            end
        end
        if (ok) begin
            wins++;
            if (wins % NCELLS == 0) r.sweep_done = 1'b1;
        end
        r.pop_one = pop[0][16:0];
        r.pop_two = pop[1][16:0];
        r.pop_three = pop[2][16:0];
        r.pop_four = pop[3][16:0];
        r.pop_five = pop[4][16:0];
        r.success_count = wins;
        r.extinct = (pop[0] == 0 || pop[1] == 0 || pop[2] == 0 || pop[3] == 0 ||
                     pop[4] == 0);
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            CFG_REPRODUCE: p_repro = val;
            CFG_COMPETE: p_comp = val;
            CFG_WEAK_EARLY: p_weak_e = val;
            default: p_weak_l = val;
        endcase
    endtask

    task automatic send_item(t_in_item it, bit gold_known, t_out_item gold);
        t_out_item want;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = lattice_step(it);
        if (want.outcome == OUT_MOVED) n_moves++;
        if (want.outcome == OUT_PREDATED) n_preds++;
        if (want.outcome == OUT_REPRODUCED) n_repros++;
        if (gold_known) want = gold;
        due_q.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (due_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_item);
            end else begin
                want = due_q.pop_front();
                if (o_item !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, o_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no progress, %0d results pending", due_q.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int lo;
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end else begin
                lo = random_stall ? $urandom_range(0, 3) : 0;
                if (lo != 0) begin
                    i_ready <= 1'b0;
                    repeat (lo) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    typedef struct {
        t_in_item it;
        bit gold_known;
        t_out_item gold;
    } t_row;

    function automatic t_in_item mk(logic rq, int x, int y, int sp, int dir, int ad, int wd);
        t_in_item it;
        it.req_type = rq;
        it.cell_x = x[7:0];
        it.cell_y = y[7:0];
        it.load_species = sp[2:0];
        it.direction = dir[2:0];
        it.action_draw = ad[15:0];
        it.weakness_draw = wd[15:0];
        return it;
    endfunction

    function automatic t_out_item quiet(logic [2:0] oc);
        t_out_item r;
        r = '0;
        r.outcome = oc;
        r.extinct = 1'b1;
        return r;
    endfunction

    initial begin
        t_row rows [$];
        t_in_item it;
        int cx, cy, r;
        for (int i = 0; i < NCELLS; i++) grid[i] = SPECIES_EMPTY;
        for (int i = 0; i < 5; i++) pop[i] = 0;
        wins = 0;
        p_repro = REPRODUCE_RST;
        p_comp = COMPETE_RST;
        p_weak_e = WEAK_EARLY_RST;
        p_weak_l = WEAK_LATE_RST;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Known answers straight after reset, then a hand-built neighborhood.
        rows.push_back('{mk(REQ_EVENT, 255, 255, 0, 7, 65535, 65535), 1, quiet(OUT_EMPTY)});
        rows.push_back('{mk(REQ_EVENT, 0, 0, 7, 0, 0, 0), 1, quiet(OUT_EMPTY)});
        rows.push_back('{mk(REQ_LOAD, 0, 0, 7, 0, 0, 0), 1, quiet(OUT_LOADED)});
        rows.push_back('{mk(REQ_LOAD, 0, 0, 6, 0, 0, 0), 1, quiet(OUT_LOADED)});
        for (int s = 1; s <= 5; s++)
            rows.push_back('{mk(REQ_LOAD, s, 0, s, 0, 0, 0), 0, '0});
        rows.push_back('{mk(REQ_LOAD, 0, 0, 5, 0, 0, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 0, 0, 0, DIR_XP, 40000, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 1, 0, 0, DIR_XP, 40000, 65535), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 3, 0, 0, DIR_XP, 0, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 0, 0, 0, DIR_XM, 0, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 0, 0, 0, DIR_YM, 100, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 0, 0, 0, DIR_XMYM, 65535, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 2, 0, 0, DIR_YP, 60000, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 2, 0, 0, DIR_XPYP, 60000, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 4, 0, 0, DIR_XMYP, 1, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 4, 0, 0, DIR_XPYM, 49151, 0), 0, '0});
        rows.push_back('{mk(REQ_EVENT, 3, 0, 0, DIR_XPYM, 49152, 0), 0, '0});
        rows.push_back('{mk(REQ_LOAD, 3, 0, 0, 0, 0, 0), 0, '0});
        foreach (rows[i]) send_item(rows[i].it, rows[i].gold_known, rows[i].gold);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_REPRODUCE, 17'd0); write_reg(CFG_COMPETE, 17'd65536); end
                1: begin write_reg(CFG_WEAK_EARLY, 17'd0); write_reg(CFG_WEAK_LATE, 17'd32768); end
                2: begin write_reg(CFG_REPRODUCE, 17'd65536); write_reg(CFG_COMPETE, 17'd0); end
                3: begin write_reg(CFG_REPRODUCE, 17'd20000); write_reg(CFG_COMPETE, 17'd65536);
                          write_reg(CFG_WEAK_EARLY, 17'd65536); write_reg(CFG_WEAK_LATE, 17'd0); end
                4: begin write_reg(CFG_REPRODUCE, 17'd0); write_reg(CFG_COMPETE, 17'd0); end
                default: begin write_reg(CFG_REPRODUCE, 17'd21845);
                               write_reg(CFG_COMPETE, 17'd21845);
                               write_reg(CFG_WEAK_EARLY, 17'd40000);
                               write_reg(CFG_WEAK_LATE, 17'd50000); end
            endcase
            i_cfg_we <= 1'b0;
            random_stall = (ph % 3 != 0);
            if (ph == 2) hold_off = 1'b1;
            // Events cluster in a small window so neighbors interact; a few land anywhere.
            for (int n = 0; n < 215; n++) begin
                r = $urandom_range(0, 99);
                cx = (r < 90) ? $urandom_range(0, 7) : $urandom_range(0, 255);
                cy = (r < 90) ? 8'd254 + $urandom_range(0, 5) : $urandom_range(0, 255);
                it = mk(($urandom_range(0, 99) < 30) ? REQ_LOAD : REQ_EVENT, cx, cy,
                        $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
                send_item(it, 0, '0);
                if (n == 100) drain();
            end
            drain();
        end

        $display("covered %0d results: %0d reproductions, %0d predations, %0d moves,",
                 results_seen, n_repros, n_preds, n_moves);
        $display("six register settings including both band extremes and stalls");
        if (mismatches == 0 && due_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, due_q.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
